// ----- rtl/core/utf8_sanitize_markup_escape_assert.svh -----
// Assertion macros for the text sanitiser block.
`ifndef UTF8_SANITIZE_MARKUP_ESCAPE_ASSERT_SVH
`define UTF8_SANITIZE_MARKUP_ESCAPE_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define U8SE_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("u8se assertion failed");

// Next-cycle implication, disabled while reset is low.
`define U8SE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("u8se assertion failed");

`endif

// ----- rtl/core/u8se_pkg.sv -----
// Shared types, constants and helper functions of the text sanitiser.
`default_nettype none
package u8se_pkg;

    localparam int unsigned CFG_W       = 10;
    localparam int unsigned COUNT_WIDTH = 10;
    localparam int unsigned UNIT_MAX    = 5;
    localparam int unsigned LEN_W       = 3;

    localparam logic [CFG_W-1:0] MAX_OUT_RESET = CFG_W'(103);

    typedef logic [7:0]                t_byte;
    typedef logic [UNIT_MAX-1:0][7:0]  t_seq;
    typedef logic [LEN_W-1:0]          t_len;

    // Markup characters and their escapes (byte 0 sent first)
    localparam t_byte CH_AMP = 8'h26;
    localparam t_byte CH_LT  = 8'h3C;
    localparam t_byte CH_GT  = 8'h3E;

    localparam t_seq ESC_AMP = {8'h3B, 8'h70, 8'h6D, 8'h61, 8'h26};
    localparam t_seq ESC_LT  = {8'h00, 8'h3B, 8'h74, 8'h6C, 8'h26};
    localparam t_seq ESC_GT  = {8'h00, 8'h3B, 8'h74, 8'h67, 8'h26};

    localparam t_len LEN_AMP = 3'd5;
    localparam t_len LEN_LT  = 3'd4;
    localparam t_len LEN_GT  = 3'd4;

    // One unit of work handed to the output serialiser
    typedef struct packed {
        t_seq       bytes;
        t_len       n;
        logic       term;
        logic       trunc;
    } t_unit;

    // Sequence length announced by a lead byte, zero for an invalid lead
    function automatic t_len lead_length(input t_byte b);
        t_len len;
        if ((b & 8'h80) == 8'h00)      len = 3'd1;
        else if ((b & 8'hE0) == 8'hC0) len = 3'd2;
        else if ((b & 8'hF0) == 8'hE0) len = 3'd3;
        else if ((b & 8'hF8) == 8'hF0) len = 3'd4;
        else                           len = 3'd0;
        return len;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/core/u8se_if.sv -----
// Stream and configuration channel interfaces of the text sanitiser.
`default_nettype none
interface u8se_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       has_byte;
    logic       end_of_text;

    modport source (output valid, output in_byte, output has_byte, output end_of_text,
                    input ready);
    modport sink   (input valid, input in_byte, input has_byte, input end_of_text,
                    output ready);
endinterface

interface u8se_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_valid;
    logic       out_last;
    logic       truncated;

    modport source (output valid, output out_byte, output out_valid, output out_last,
                    output truncated, input ready);
    modport sink   (input valid, input out_byte, input out_valid, input out_last,
                    input truncated, output ready);
endinterface

interface u8se_cfg_if;
    logic       valid;
    logic       ready;
    logic [9:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/u8se_serial.sv -----
// Output serialiser: holds one unit and sends its results one per transfer.
`default_nettype none
module u8se_serial (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire u8se_pkg::t_unit i_unit,
    input  wire logic          i_load,
    output logic               o_take,
    u8se_out_if.source         o_out
);
    import u8se_pkg::*;

    t_unit r_unit;
    logic  r_active;
    t_len  r_idx;

    t_len  total;
    logic  xfer;
    logic  last_xfer;

    // Results in the held unit: its bytes plus an optional terminator
    assign total     = r_unit.n + t_len'(r_unit.term);
    assign xfer      = o_out.valid && o_out.ready;
    assign last_xfer = xfer && (r_idx == total - 3'd1);
    assign o_take    = !r_active || last_xfer;

    // Present the current result
    always_comb begin
        o_out.valid = r_active;
        if (r_idx < r_unit.n) begin
            o_out.out_byte  = r_unit.bytes[r_idx];
            o_out.out_valid = 1'b1;
            o_out.out_last  = 1'b0;
            o_out.truncated = 1'b0;
        end else begin
            o_out.out_byte  = 8'h00;
            o_out.out_valid = 1'b0;
            o_out.out_last  = 1'b1;
            o_out.truncated = r_unit.trunc;
        end
    end

    // Unit buffer and result index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_idx    <= '0;
        end else if (i_load) begin
            r_active <= 1'b1;
            r_idx    <= '0;
        end else if (last_xfer) begin
            r_active <= 1'b0;
        end else if (xfer) begin
            r_idx <= r_idx + 3'd1;
        end
        if (i_load) begin
            r_unit <= i_unit;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/core/utf8_sanitize_markup_escape.sv -----
// Latency: a byte accepted at one edge shows its first result in the next cycle.
// Throughput: one input byte per cycle while the output is not stalled and each byte
// gives at most one result; an item giving more than one result (escapes, multi-byte
// characters, terminator) holds the input until the single-byte output serialiser has sent them.
// Reset: synchronous, active low; clears the pending sequence, the byte count,
// the cut flag and the output buffer, and sets the capacity to 103.
`default_nettype none
`include "utf8_sanitize_markup_escape_assert.svh"
module utf8_sanitize_markup_escape (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    u8se_in_if.sink    i_in,
    u8se_out_if.source o_out,
    u8se_cfg_if.sink   i_cfg
);
    import u8se_pkg::*;

    localparam int unsigned SUM_W = ((COUNT_WIDTH > CFG_W) ? COUNT_WIDTH : CFG_W) + 1;
    localparam logic [SUM_W-1:0] COUNT_MAX = SUM_W'((1 << COUNT_WIDTH) - 1);

    logic [CFG_W-1:0]       r_max;
    logic [23:0]            r_pend,  n_pend;
    t_len                   r_exp,   n_exp;
    t_len                   r_have,  n_have;
    logic [COUNT_WIDTH-1:0] r_count, n_count;
    logic                   r_stopped, n_stopped;

    t_unit            unit;
    logic             take;
    logic             in_xfer;
    logic             use_lead;
    logic             emit_req;
    t_len             emit_n;
    t_seq             emit_seq;
    t_len             len;
    t_byte            b;
    logic [SUM_W-1:0] cap;
    logic [SUM_W-1:0] sum;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = take;
    assign in_xfer     = i_in.valid && i_in.ready;
    assign b           = i_in.in_byte;

    // Capacity limited to what the counter can hold
    assign cap = (SUM_W'(r_max) > COUNT_MAX) ? COUNT_MAX : SUM_W'(r_max);
    assign sum = SUM_W'(r_count) + SUM_W'(emit_n);

    // Decode one input item into a unit of results and the next state
    always_comb begin
        n_pend    = r_pend;
        n_exp     = r_exp;
        n_have    = r_have;
        n_count   = r_count;
        n_stopped = r_stopped;
        unit      = '0;
        use_lead  = 1'b0;
        emit_req  = 1'b0;
        emit_n    = '0;
        emit_seq  = '0;
        len       = lead_length(b);

        if (in_xfer && i_in.has_byte && !r_stopped) begin
            use_lead = 1'b1;
            if (r_exp != 3'd0) begin
                if (b[7:6] == 2'b10 && r_have < r_exp) begin
                    use_lead = 1'b0;
                    if (r_have + 3'd1 == r_exp) begin
                        // sequence complete
                        emit_req = 1'b1;
                        emit_n   = r_exp;
                        case (r_exp)
                            3'd2:    emit_seq = {24'h0, b, r_pend[7:0]};
                            3'd3:    emit_seq = {16'h0, b, r_pend[15:0]};
                            default: emit_seq = {8'h0, b, r_pend[23:0]};
                        endcase
                        n_pend = '0;
                        n_exp  = '0;
                        n_have = '0;
                    end else begin
                        case (r_have)
                            3'd1:    n_pend[15:8]  = b;
                            3'd2:    n_pend[23:16] = b;
                            default: n_pend        = r_pend;
                        endcase
                        n_have = r_have + 3'd1;
                    end
                end else begin
                    // broken continuation: drop it, rescan this byte as a lead
                    n_pend = '0;
                    n_exp  = '0;
                    n_have = '0;
                end
            end

            if (use_lead) begin
                if (len == 3'd1) begin
                    emit_req = 1'b1;
                    case (b)
                        CH_AMP: begin
                            emit_seq = ESC_AMP;
                            emit_n   = LEN_AMP;
                        end
                        CH_LT: begin
                            emit_seq = ESC_LT;
                            emit_n   = LEN_LT;
                        end
                        CH_GT: begin
                            emit_seq = ESC_GT;
                            emit_n   = LEN_GT;
                        end
                        default: begin
                            emit_seq = {32'h0, b};
                            emit_n   = 3'd1;
                        end
                    endcase
                end else if (len != 3'd0) begin
                    n_pend = {16'h0, b};
                    n_exp  = len;
                    n_have = 3'd1;
                end
            end

            // Capacity check: a unit that does not fit cuts the rest of the text
            if (emit_req) begin
                if (sum > cap) begin
                    n_stopped = 1'b1;
                    n_pend    = '0;
                    n_exp     = '0;
                    n_have    = '0;
                end else begin
                    unit.bytes = emit_seq;
                    unit.n     = emit_n;
                    n_count    = sum[COUNT_WIDTH-1:0];
                end
            end
        end

        // End of text: terminator and a fresh string
        if (in_xfer && i_in.end_of_text) begin
            unit.term  = 1'b1;
            unit.trunc = n_stopped;
            n_pend     = '0;
            n_exp      = '0;
            n_have     = '0;
            n_count    = '0;
            n_stopped  = 1'b0;
        end
    end

    // Decoder state and capacity register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max     <= MAX_OUT_RESET;
            r_pend    <= '0;
            r_exp     <= '0;
            r_have    <= '0;
            r_count   <= '0;
            r_stopped <= 1'b0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                r_max <= i_cfg.data;
            end
            r_pend    <= n_pend;
            r_exp     <= n_exp;
            r_have    <= n_have;
            r_count   <= n_count;
            r_stopped <= n_stopped;
        end
    end

    // Output serialiser
    u8se_serial u_serial (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_unit  (unit),
        .i_load  (in_xfer && (unit.n != 3'd0 || unit.term)),
        .o_take  (take),
        .o_out   (o_out)
    );

    // Checks
    `U8SE_ASSERT_IMPL(a_stall_blocks_input, i_clk, i_rst_n, o_out.valid && !o_out.ready, !i_in.ready)
    `U8SE_ASSERT_IMPL(a_pending_consistent, i_clk, i_rst_n, r_exp == 3'd0, r_have == 3'd0)
    `U8SE_ASSERT_IMPL(a_have_below_len, i_clk, i_rst_n, r_exp != 3'd0, r_have < r_exp)
    `U8SE_ASSERT_NEXT(a_cut_holds_count, i_clk, i_rst_n, in_xfer && !i_in.end_of_text && r_stopped, $stable(r_count) && r_stopped)
    `U8SE_ASSERT_NEXT(a_end_clears, i_clk, i_rst_n, in_xfer && i_in.end_of_text, !r_stopped && r_count == '0 && r_exp == 3'd0)

endmodule
`default_nettype wire

// ----- tb/tb_utf8_sanitize_markup_escape.sv -----
// Self-checking testbench of the UTF-8 sanitiser with markup escaping.
`timescale 1ns / 1ps

localparam int unsigned TEXT_COUNT_MAX = (1 << u8se_pkg::COUNT_WIDTH) - 1;

// Markup characters and the text they expand to, byte 0 in the low bits
localparam logic [7:0] AMP_CHAR = "&";
localparam logic [7:0] LT_CHAR  = "<";
localparam logic [7:0] GT_CHAR  = ">";
localparam u8se_pkg::t_seq AMP_TEXT = {";", "p", "m", "a", "&"};
localparam u8se_pkg::t_seq LT_TEXT  = {8'h00, ";", "t", "l", "&"};
localparam u8se_pkg::t_seq GT_TEXT  = {8'h00, ";", "t", "g", "&"};

typedef struct packed {
    logic [7:0] out_byte;
    logic       out_valid;
    logic       out_last;
    logic       truncated;
} t_text_result;

// Tracks the sanitiser state and holds the output bytes still to arrive
class escaped_text_board;
    logic [u8se_pkg::CFG_W-1:0] capacity;
    logic [23:0]                held;
    int unsigned                seq_len;
    int unsigned                held_len;
    int unsigned                byte_count;
    bit                         cut;
    t_text_result               expected_q[$];
    int unsigned                mismatches;

    function new();
        capacity   = u8se_pkg::MAX_OUT_RESET;
        held       = '0;
        seq_len    = 0;
        held_len   = 0;
        byte_count = 0;
        cut        = 1'b0;
        mismatches = 0;
    endfunction

    function void set_capacity(logic [u8se_pkg::CFG_W-1:0] value);
        capacity = value;
    endfunction

    function void drop_held();
        held     = '0;
        seq_len  = 0;
        held_len = 0;
    endfunction

    function int unsigned char_length(logic [7:0] b);
        if (b[7] == 1'b0)          return 1;
        if (b[7:5] == 3'b110)      return 2;
        if (b[7:4] == 4'b1110)     return 3;
        if (b[7:3] == 5'b11110)    return 4;
        return 0;
    endfunction

    // A whole character or escape goes out, or the string is cut here
    function void emit(u8se_pkg::t_seq s, int unsigned n);
        int unsigned  limit;
        int unsigned  i;
        t_text_result r;
        limit = 32'(capacity);
        if (limit > TEXT_COUNT_MAX) limit = TEXT_COUNT_MAX;
        if (byte_count + n > limit) begin
            cut = 1'b1;
            drop_held();
            return;
        end
        for (i = 0; i < n; i++) begin
            r.out_byte  = s[i];
            r.out_valid = 1'b1;
            r.out_last  = 1'b0;
            r.truncated = 1'b0;
            expected_q.push_back(r);
        end
        byte_count = (byte_count + n) & TEXT_COUNT_MAX;
    endfunction

    function void take_byte(logic [7:0] b);
        u8se_pkg::t_seq s;
        int unsigned    n;
        int unsigned    i;
        if (cut) return;
        if (seq_len != 0) begin
            if (b[7:6] == 2'b10 && held_len < 4 && held_len < seq_len) begin
                if (held_len + 1 == seq_len) begin
                    s = '0;
                    for (i = 0; i < held_len && i < 3; i++) s[i] = held[8*i +: 8];
                    s[held_len] = b;
                    n = seq_len;
                    drop_held();
                    emit(s, n);
                    return;
                end
                if (held_len < 3) held[8*held_len +: 8] = held[8*held_len +: 8] | b;
                held_len++;
                return;
            end
            // broken continuation: the byte is rescanned as a lead
            drop_held();
        end
        n = char_length(b);
        if (n == 0) return;
        if (n == 1) begin
            if (b == AMP_CHAR)     emit(AMP_TEXT, 5);
            else if (b == LT_CHAR) emit(LT_TEXT, 4);
            else if (b == GT_CHAR) emit(GT_TEXT, 4);
            else begin
                s    = '0;
                s[0] = b;
                emit(s, 1);
            end
            return;
        end
        held     = {16'h0000, b};
        seq_len  = n;
        held_len = 1;
    endfunction

    // Called for every input transfer
    function void accept_item(logic [7:0] b, bit has, bit eot);
        t_text_result r;
        if (has) take_byte(b);
        if (eot) begin
            r.out_byte  = 8'h00;
            r.out_valid = 1'b0;
            r.out_last  = 1'b1;
            r.truncated = cut;
            expected_q.push_back(r);
            drop_held();
            byte_count = 0;
            cut        = 1'b0;
        end
    endfunction

    // Called for every output transfer
    function void match_result(t_text_result got);
        t_text_result want;
        if (expected_q.size() == 0) begin
            if (mismatches < 10)
                $display("%0t: unexpected output byte=%h valid=%b last=%b trunc=%b",
                         $time, got.out_byte, got.out_valid, got.out_last, got.truncated);
            mismatches++;
            return;
        end
        want = expected_q.pop_front();
        if (got.out_byte !== want.out_byte || got.out_valid !== want.out_valid ||
            got.out_last !== want.out_last || got.truncated !== want.truncated) begin
            if (mismatches < 10)
                $display({"%0t: mismatch exp byte=%h valid=%b last=%b trunc=%b,",
                          " got byte=%h valid=%b last=%b trunc=%b"},
                         $time, want.out_byte, want.out_valid, want.out_last,
                         want.truncated, got.out_byte, got.out_valid, got.out_last,
                         got.truncated);
            mismatches++;
        end
    endfunction
endclass

module tb_utf8_sanitize_markup_escape;

    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned SETTLE_CYCLES  = 8;
    localparam int unsigned TAIL_CYCLES    = 20;
    localparam int unsigned PHASE_ITEMS    = 64;
    localparam int unsigned NUM_PHASES     = 5;

    typedef logic [u8se_pkg::CFG_W-1:0] t_cap;
    typedef enum {STALL_NONE, STALL_COIN, STALL_PERIODIC, STALL_HEAVY} t_rx_mode;
    typedef enum {
        UNIT_ASCII, UNIT_MARKUP, UNIT_TWO, UNIT_THREE, UNIT_FOUR,
        UNIT_BAD_LEAD, UNIT_BROKEN, UNIT_IDLE, UNIT_END
    } t_unit_kind;

    logic i_clk;
    logic i_rst_n;

    u8se_in_if  in_if ();
    u8se_out_if out_if ();
    u8se_cfg_if cfg_if ();

    utf8_sanitize_markup_escape DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    escaped_text_board board;
    int unsigned       burst_left;
    int unsigned       idle_cycles;
    t_rx_mode          rx_mode;
    int unsigned       rx_mode_left;
    int unsigned       rx_tick;

    // Clock
    always #5 i_clk = ~i_clk;

    // Receiver stall pattern, changing mode every so often
    always @(negedge i_clk) begin
        if (rx_mode_left == 0) begin
            rx_mode      = t_rx_mode'($urandom_range(0, 3));
            rx_mode_left = $urandom_range(20, 150);
            rx_tick      = 0;
        end
        rx_mode_left--;
        rx_tick++;
        case (rx_mode)
            STALL_NONE:     out_if.ready = 1'b1;
            STALL_COIN:     out_if.ready = 1'($urandom_range(0, 1));
            STALL_PERIODIC: out_if.ready = (rx_tick % 5) < 3;
            default:        out_if.ready = ($urandom_range(0, 3) == 0);
        endcase
    end

    // Output transfers go to the checker
    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready)
            board.match_result('{out_if.out_byte, out_if.out_valid,
                                 out_if.out_last, out_if.truncated});
    end

    // Watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
            (cfg_if.valid && cfg_if.ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // One input item; entered and left at a falling edge, valid left high
    task automatic send_item(input logic [7:0] b, input bit has, input bit eot);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                in_if.valid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 16);
        end
        burst_left--;
        in_if.in_byte     = b;
        in_if.has_byte    = has;
        in_if.end_of_text = eot;
        in_if.valid       = 1'b1;
        forever begin
            @(posedge i_clk);
            if (in_if.ready) break;
        end
        board.accept_item(b, has, eot);
        @(negedge i_clk);
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_item(b, 1'b1, 1'b0);
    endtask

    // Sender holds off until every expected byte has come out
    task automatic drain_outputs();
        in_if.valid = 1'b0;
        burst_left  = 0;
        while (board.expected_q.size() != 0) @(negedge i_clk);
    endtask

    // Capacity write, only with the block idle
    task automatic write_capacity(input t_cap value);
        drain_outputs();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        cfg_if.data  = value;
        cfg_if.valid = 1'b1;
        forever begin
            @(posedge i_clk);
            if (cfg_if.ready) break;
        end
        board.set_capacity(value);
        @(negedge i_clk);
        cfg_if.valid = 1'b0;
    endtask

    function automatic logic [7:0] cont_byte();
        return {2'b10, 6'($urandom)};
    endfunction

    function automatic logic [7:0] lead_of(int unsigned len);
        case (len)
            2:       return {3'b110, 5'($urandom)};
            3:       return {4'b1110, 4'($urandom)};
            default: return {5'b11110, 3'($urandom)};
        endcase
    endfunction

    function automatic t_unit_kind pick_kind();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 30) return UNIT_ASCII;
        if (r < 40) return UNIT_MARKUP;
        if (r < 55) return UNIT_TWO;
        if (r < 67) return UNIT_THREE;
        if (r < 77) return UNIT_FOUR;
        if (r < 83) return UNIT_BAD_LEAD;
        if (r < 89) return UNIT_BROKEN;
        if (r < 93) return UNIT_IDLE;
        return UNIT_END;
    endfunction

    // One random character, fault or string end; counts items that do something
    task automatic send_random_unit(output int unsigned counted);
        t_unit_kind  kind;
        int unsigned len;
        int unsigned k;
        int unsigned i;
        logic [7:0]  b;
        kind    = pick_kind();
        counted = 0;
        case (kind)
            UNIT_ASCII: begin
                send_byte(8'($urandom_range(0, 127)));
                counted = 1;
            end
            UNIT_MARKUP: begin
                case ($urandom_range(0, 2))
                    0:       send_byte(AMP_CHAR);
                    1:       send_byte(LT_CHAR);
                    default: send_byte(GT_CHAR);
                endcase
                counted = 1;
            end
            UNIT_TWO, UNIT_THREE, UNIT_FOUR: begin
                len = (kind == UNIT_TWO) ? 2 : (kind == UNIT_THREE) ? 3 : 4;
                send_byte(lead_of(len));
                for (i = 1; i < len; i++) send_byte(cont_byte());
                counted = len;
            end
            UNIT_BAD_LEAD: begin
                b = ($urandom_range(0, 1) == 0) ? cont_byte() : {5'b11111, 3'($urandom)};
                send_byte(b);
                counted = 1;
            end
            UNIT_BROKEN: begin
                len = $urandom_range(2, 4);
                k   = $urandom_range(0, len - 2);
                send_byte(lead_of(len));
                for (i = 0; i < k; i++) send_byte(cont_byte());
                if ($urandom_range(0, 1) == 0) begin
                    // left unfinished at the end of the string
                    send_item(8'($urandom), 1'b0, 1'b1);
                end else begin
                    do b = 8'($urandom); while (b[7:6] == 2'b10);
                    send_byte(b);
                end
                counted = k + 2;
            end
            UNIT_IDLE: begin
                send_item(8'($urandom), 1'b0, 1'b0);
            end
            default: begin
                send_item(8'($urandom), 1'($urandom_range(0, 1)), 1'b1);
                counted = 1;
            end
        endcase
    endtask

    // Stimulus
    initial begin
        t_cap        caps [NUM_PHASES];
        int unsigned counted;
        int unsigned phase_items;
        int unsigned pause_at;
        bit          paused;
        int unsigned p;

        board              = new();
        i_clk              = 1'b0;
        i_rst_n            = 1'b0;
        in_if.valid        = 1'b0;
        in_if.in_byte      = 8'h00;
        in_if.has_byte     = 1'b0;
        in_if.end_of_text  = 1'b0;
        out_if.ready       = 1'b0;
        cfg_if.valid       = 1'b0;
        cfg_if.data        = '0;
        burst_left         = 0;
        idle_cycles        = 0;
        rx_mode            = STALL_NONE;
        rx_mode_left       = 0;
        rx_tick            = 0;

        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: reset capacity, byte extremes, escapes, every sequence length
        send_byte(8'h00);
        send_byte(8'h7F);
        send_byte(AMP_CHAR);
        send_byte(LT_CHAR);
        send_byte(GT_CHAR);
        send_byte(8'hC3); send_byte(8'hA9);
        send_byte(8'hE2); send_byte(8'h82); send_byte(8'hAC);
        send_byte(8'hF0); send_byte(8'h9F); send_byte(8'h98); send_byte(8'h80);
        // invalid leads, then a continuation that breaks
        send_byte(8'hFF);
        send_byte(8'h80);
        send_byte(8'hC3); send_byte(8'h41);
        send_item(8'h00, 1'b0, 1'b0);
        // sequence left open at the end of the string
        send_byte(8'hE2); send_byte(8'h82);
        send_item(8'h00, 1'b0, 1'b1);

        // Nothing fits with capacity zero
        write_capacity('0);
        send_item("A", 1'b1, 1'b1);

        // Escape too long for the capacity, then a byte after the cut
        write_capacity(t_cap'(4));
        send_byte(AMP_CHAR);
        send_item("B", 1'b1, 1'b1);

        // Random phases over a spread of capacities
        caps[0] = '1;
        caps[1] = t_cap'(1);
        caps[2] = t_cap'($urandom_range(5, 40));
        caps[3] = t_cap'($urandom_range(1, 1023));
        caps[4] = t_cap'($urandom_range(2, 12));
        for (p = 0; p < NUM_PHASES; p++) begin
            write_capacity(caps[p]);
            phase_items = 0;
            pause_at    = $urandom_range(10, 50);
            paused      = 1'b0;
            while (phase_items < PHASE_ITEMS) begin
                send_random_unit(counted);
                phase_items += counted;
                if (!paused && phase_items >= pause_at) begin
                    drain_outputs();
                    paused = 1'b1;
                end
            end
        end

        drain_outputs();
        repeat (TAIL_CYCLES) @(negedge i_clk);

        if (board.mismatches == 0 && board.expected_q.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            if (board.expected_q.size() != 0)
                $display("%0d expected results never arrived", board.expected_q.size());
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
